[rtl/core/zrle_pkg.sv]
// zrle_pkg: shared types and constants of the zero run-length sample encoder
// used by every module under rtl/core
`default_nettype none

package zrle_pkg;

   localparam int unsigned DataWidth  = 8;
   localparam int unsigned MaxBytes   = 3;
   localparam int unsigned CntWidth   = $clog2(MaxBytes + 1);
   localparam int unsigned AddrWidth  = 4;
   localparam int unsigned CsrWidth   = 32;

   typedef logic [DataWidth-1:0] byte_type;
   typedef logic [CntWidth-1:0]  num_type;

   // register index in the csr space (byte address / 4)
   typedef enum logic [1:0] {
      REG_MIN_SEND  = 2'd0,
      REG_MAX_SEND  = 2'd1,
      REG_RUN_LIMIT = 2'd2
   } reg_index_type;

   localparam byte_type MinSendReset  = 8'd1;
   localparam byte_type MaxSendReset  = 8'd254;
   localparam byte_type RunLimitReset = 8'd254;
   localparam byte_type RunMarker     = 8'd0;

   typedef struct packed {
      byte_type min_send_value;
      byte_type max_send_value;
      byte_type zero_run_limit;
   } cfg_type;

   // bytes caused by one sample, slot 0 goes out first
   typedef struct packed {
      byte_type [MaxBytes-1:0] bytes;
      num_type                 num;
   } burst_type;

endpackage

`default_nettype wire

[rtl/core/zero_run_length_sample_encoder.sv]
// zero_run_length_sample_encoder: zero run-length encoder for 8-bit samples
// bytes of a sample go from the hold register to the single output register
// one result byte per cycle while rsp_stall is low; a sample causes 0 to 3
// bytes, and the next is taken as the last byte leaves the hold register
// reset clears the run count and sets the registers to 1, 254, 254
// depends on zrle_pkg, zrle_csr, zrle_encode, zrle_burst
`default_nettype none

module zero_run_length_sample_encoder (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [zrle_pkg::DataWidth-1:0] req_sample,
   input  wire logic                          req_frame_end,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [zrle_pkg::DataWidth-1:0] rsp_out_byte,
   output logic                               rsp_last,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [zrle_pkg::AddrWidth-1:0] csr_paddr,
   input  wire logic [zrle_pkg::CsrWidth-1:0]  csr_pwdata,
   output logic      [zrle_pkg::CsrWidth-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import zrle_pkg::*;

   cfg_type   cfg;
   burst_type burst;
   logic      can_take;
   logic      accept;

   assign req_stall = !can_take;
   assign accept    = req_valid && can_take;

   zrle_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   zrle_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .sample    (req_sample),
      .frame_end (req_frame_end),
      .cfg       (cfg),
      .burst     (burst)
   );

   zrle_burst u_burst (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .burst        (burst),
      .can_take     (can_take),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

[rtl/core/zrle_csr.sv]
// zrle_csr: apb-style configuration registers of the encoder
// depends on zrle_pkg
`default_nettype none

module zrle_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [zrle_pkg::AddrWidth-1:0] csr_paddr,
   input  wire logic [zrle_pkg::CsrWidth-1:0]  csr_pwdata,
   output logic      [zrle_pkg::CsrWidth-1:0]  csr_prdata,
   output logic                               csr_pready,
   output zrle_pkg::cfg_type                  cfg
);
   import zrle_pkg::*;

   byte_type      min_send_ff, min_send_in;
   byte_type      max_send_ff, max_send_in;
   byte_type      run_limit_ff, run_limit_in;
   logic          wr_en;
   reg_index_type index;
   byte_type      rd_byte;

   assign index      = reg_index_type'(csr_paddr[AddrWidth-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      min_send_in  = min_send_ff;
      max_send_in  = max_send_ff;
      run_limit_in = run_limit_ff;
      if (wr_en) begin
         case (index)
            REG_MIN_SEND:  min_send_in  = csr_pwdata[DataWidth-1:0];
            REG_MAX_SEND:  max_send_in  = csr_pwdata[DataWidth-1:0];
            REG_RUN_LIMIT: run_limit_in = csr_pwdata[DataWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_send_ff  <= MinSendReset;
         max_send_ff  <= MaxSendReset;
         run_limit_ff <= RunLimitReset;
      end else begin
         min_send_ff  <= min_send_in;
         max_send_ff  <= max_send_in;
         run_limit_ff <= run_limit_in;
      end
   end

   always_comb begin
      case (index)
         REG_MIN_SEND:  rd_byte = min_send_ff;
         REG_MAX_SEND:  rd_byte = max_send_ff;
         REG_RUN_LIMIT: rd_byte = run_limit_ff;
         default:       rd_byte = '0;
      endcase
   end

   assign csr_prdata         = {{(CsrWidth-DataWidth){1'b0}}, rd_byte};
   assign cfg.min_send_value = min_send_ff;
   assign cfg.max_send_value = max_send_ff;
   assign cfg.zero_run_limit = run_limit_ff;

endmodule

`default_nettype wire

[rtl/core/zrle_encode.sv]
// zrle_encode: run counter and per-sample byte list of the encoder
// depends on zrle_pkg
`default_nettype none

module zrle_encode (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [zrle_pkg::DataWidth-1:0] sample,
   input  wire logic                          frame_end,
   input  zrle_pkg::cfg_type                  cfg,
   output zrle_pkg::burst_type                burst
);
   import zrle_pkg::*;

   byte_type run_cnt_ff, run_cnt_in;
   byte_type cnt_after;
   byte_type send_value;
   logic     below;
   logic     run_full;
   logic     pair_en;
   logic     send_en;
   logic     flush_en;
   byte_type pair_value;

   assign below    = sample < cfg.min_send_value;
   // count + 1 < limit, never true for a limit of zero
   assign run_full = below &&
                     !(({1'b0, run_cnt_ff} + 9'd1) < {1'b0, cfg.zero_run_limit});
   assign pair_en  = run_full || (!below && (run_cnt_ff != '0));
   assign pair_value = run_full ? cfg.zero_run_limit : run_cnt_ff;

   always_comb begin
      if (below && !run_full) begin
         cnt_after = run_cnt_ff + 8'd1;
      end else begin
         cnt_after = '0;
      end
   end

   assign send_en    = (sample > cfg.max_send_value) || !below;
   assign send_value = (sample > cfg.max_send_value) ? cfg.max_send_value : sample;
   assign flush_en   = frame_end && (cnt_after != '0);
   assign run_cnt_in = flush_en ? '0 : cnt_after;

   always_comb begin
      burst.num = num_type'({1'b0, pair_en, 1'b0} + {2'b00, send_en} +
                            {1'b0, flush_en, 1'b0});
      if (pair_en) begin
         burst.bytes = {send_value, pair_value, RunMarker};
      end else if (send_en) begin
         burst.bytes = {cnt_after, RunMarker, send_value};
      end else begin
         burst.bytes = {RunMarker, cnt_after, RunMarker};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_cnt_ff <= '0;
      end else if (accept) begin
         run_cnt_ff <= run_cnt_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/zrle_burst.sv]
// zrle_burst: holds the bytes of one sample and sends them one per transfer
// depends on zrle_pkg
`default_nettype none

module zrle_burst (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  zrle_pkg::burst_type                burst,
   output logic                               can_take,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [zrle_pkg::DataWidth-1:0] rsp_out_byte,
   output logic                               rsp_last
);
   import zrle_pkg::*;

   burst_type hold_ff, hold_in;
   logic      valid_ff, valid_in;
   byte_type  byte_ff, byte_in;
   logic      last_ff, last_in;
   logic      out_free;
   logic      pop;

   assign out_free = !valid_ff || !rsp_stall;
   assign pop      = out_free && (hold_ff.num != '0);
   assign can_take = (hold_ff.num == '0) || ((hold_ff.num == num_type'(1)) && pop);

   always_comb begin
      hold_in  = hold_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (out_free) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         valid_in      = 1'b1;
         byte_in       = hold_ff.bytes[0];
         last_in       = hold_ff.num == num_type'(1);
         hold_in.num   = hold_ff.num - num_type'(1);
         hold_in.bytes = {RunMarker, hold_ff.bytes[MaxBytes-1:1]};
      end
      if (load) begin
         hold_in = burst;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff.bytes <= hold_in.bytes;
      byte_ff       <= byte_in;
      last_ff       <= last_in;
      if (reset) begin
         hold_ff.num <= '0;
         valid_ff    <= 1'b0;
      end else begin
         hold_ff.num <= hold_in.num;
         valid_ff    <= valid_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

endmodule

`default_nettype wire
